FILE: design/ptf_pkg.sv
// Shared types, codes and defaults for the pan/tilt target follower.
package ptf_pkg;

  localparam int IMAGE_WIDTH_DEF  = 640;
  localparam int IMAGE_HEIGHT_DEF = 480;
  localparam int MISS_LIMIT_DEF   = 50;

  localparam int SEED_MIN_AREA = 20;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 88;
  localparam int CFG_ADDR_W  = 5;

  localparam logic [18:0] MIN_AREA_RST = 19'd20;
  localparam logic [18:0] MAX_AREA_RST = 19'd307200;
  localparam logic [8:0]  DEADBAND_RST = 9'd50;
  localparam logic [7:0]  PAN_MIN_RST  = 8'd0;
  localparam logic [7:0]  PAN_MAX_RST  = 8'd180;
  localparam logic [7:0]  TILT_MIN_RST = 8'd60;
  localparam logic [7:0]  TILT_MAX_RST = 8'd140;
  localparam logic [7:0]  PAN_POS_RST  = 8'd90;
  localparam logic [7:0]  TILT_POS_RST = 8'd70;

  typedef enum logic [1:0] {
    CMD_TRACK  = 2'd0,
    CMD_SEED   = 2'd1,
    CMD_REPORT = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_NONE      = 3'd0,
    ST_SEED_LOST = 3'd1,
    ST_START     = 3'd2,
    ST_MISS_WAIT = 3'd3,
    ST_MISS_LOST = 3'd4,
    ST_ON_TARGET = 3'd5,
    ST_STEP      = 3'd6,
    ST_AT_LIMIT  = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    REG_TRACK_EN = 3'd0,
    REG_MIN_AREA = 3'd1,
    REG_MAX_AREA = 3'd2,
    REG_DEADBAND = 3'd3,
    REG_PAN_MIN  = 3'd4,
    REG_PAN_MAX  = 3'd5,
    REG_TILT_MIN = 3'd6,
    REG_TILT_MAX = 3'd7
  } reg_idx_t;

endpackage

FILE: design/pan_tilt_target_follower_core.sv
// Pan/tilt target follower: box checks, miss budget and one-degree servo stepping.
//
//  channel | direction | handshake              | payload
//  in_     | slave     | in_tvalid / in_tready  | tuser cmd, tdata box and servo report
//  out_    | master    | out_tvalid / out_tready| tuser status, tdata box, centre, servo
//  cfg_    | APB slave | psel, penable, pready  | 8 registers at byte address 4*i
//
// One word in, one word out: the whole step runs between the input port and the output
// register, so a new word is taken every cycle while the output is not stalled.
// Reset is synchronous; all state and registers but the output word reset at once.
// A stalled output holds its word; input is taken again in the cycle that word is taken.
module pan_tilt_target_follower_core #(
  parameter int IMAGE_WIDTH  = ptf_pkg::IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = ptf_pkg::IMAGE_HEIGHT_DEF,
  parameter int MISS_LIMIT   = ptf_pkg::MISS_LIMIT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // cmd
  input  logic [1:0]                      in_tuser,
  // box_left, box_top, box_right, box_bottom, report_tilt, report_pan
  input  logic [ptf_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // status
  output logic [2:0]                      out_tuser,
  // out_left, out_top, out_right, out_bottom, centre_x, centre_y,
  // servo_valid, tilt_cmd, pan_cmd, in_tracking, 2 zero bits
  output logic [ptf_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [ptf_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);

  localparam logic signed [12:0] IMG_W  = 13'(IMAGE_WIDTH);
  localparam logic signed [12:0] IMG_H  = 13'(IMAGE_HEIGHT);
  localparam logic signed [11:0] HALF_W = 12'(IMAGE_WIDTH / 2);
  localparam logic signed [11:0] HALF_H = 12'(IMAGE_HEIGHT / 2);
  localparam logic signed [6:0]  MISS_RST = 7'(MISS_LIMIT);
  localparam logic signed [25:0] SEED_AREA = 26'(ptf_pkg::SEED_MIN_AREA);

  // configuration registers
  logic        track_en_r;
  logic [18:0] min_area_r;
  logic [18:0] max_area_r;
  logic [8:0]  deadband_r;
  logic [7:0]  pan_min_r;
  logic [7:0]  pan_max_r;
  logic [7:0]  tilt_min_r;
  logic [7:0]  tilt_max_r;

  // follower state
  logic [7:0]         pan_pos_r,  pan_pos_nxt;
  logic [7:0]         tilt_pos_r, tilt_pos_nxt;
  logic signed [6:0]  miss_r,     miss_nxt;
  logic               armed_r,    armed_nxt;
  logic               flag_r,     flag_nxt;
  logic               seed_ok_r,  seed_ok_nxt;
  logic signed [11:0] seed_r [4];

  logic                            out_tvalid_r;
  logic [2:0]                      out_tuser_r;
  logic [ptf_pkg::OUT_TDATA_W-1:0] out_tdata_r;

  logic in_acc;
  logic cfg_wr;

  logic signed [11:0] b_l, b_t, b_r, b_b;
  logic [7:0]         rep_tilt, rep_pan;
  logic signed [12:0] w, h;
  logic signed [25:0] area;
  logic               box_ok;
  logic               area_ok;
  logic signed [12:0] cx13, cy13;
  logic [9:0]         cx, cy;
  logic signed [11:0] off_x, off_y;
  logic [10:0]        mag_x, mag_y;
  logic [8:0]         db_eff;
  logic               step_x, step_y;
  logic signed [9:0]  np, nt;
  logic               in_lim;
  logic signed [6:0]  miss_dec;

  ptf_pkg::status_t   status;
  logic               show_in;
  logic [9:0]         cx_o, cy_o;
  logic               servo;
  logic signed [11:0] sb_l, sb_t, sb_r, sb_b;

  assign in_acc = in_tvalid && in_tready;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  assign in_tready  = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_tuser_r;
  assign out_tdata  = out_tdata_r;
  assign cfg_pready = 1'b1;

  assign b_l      = in_tdata[11:0];
  assign b_t      = in_tdata[23:12];
  assign b_r      = in_tdata[35:24];
  assign b_b      = in_tdata[47:36];
  assign rep_tilt = in_tdata[55:48];
  assign rep_pan  = in_tdata[63:56];

  assign w    = {b_r[11], b_r} - {b_l[11], b_l};
  assign h    = {b_b[11], b_b} - {b_t[11], b_t};
  assign area = w * h;

  assign box_ok = (area >= SEED_AREA) &&
                  !b_l[11] && ({b_l[11], b_l} < IMG_W) &&
                  !b_t[11] && ({b_t[11], b_t} < IMG_H) &&
                  ({b_r[11], b_r} < IMG_W) && ({b_b[11], b_b} < IMG_H) &&
                  (w > 13'sd0) && (h > 13'sd0);

  assign area_ok = (area >= $signed({7'd0, min_area_r})) &&
                   (area <= $signed({7'd0, max_area_r}));

  assign cx13 = {b_l[11], b_l} + (w >>> 1);
  assign cy13 = {b_t[11], b_t} + (h >>> 1);
  assign cx   = cx13[9:0];
  assign cy   = cy13[9:0];

  assign off_x = $signed({2'b00, cx}) - HALF_W;
  assign off_y = $signed({2'b00, cy}) - HALF_H;
  assign mag_x = off_x[11] ? 11'(-off_x) : off_x[10:0];
  assign mag_y = off_y[11] ? 11'(-off_y) : off_y[10:0];

  assign db_eff = (deadband_r == 9'd0) ? 9'd1 : deadband_r;
  assign step_x = (off_x != 12'sd0) && (mag_x >= {2'b00, db_eff});
  assign step_y = (off_y != 12'sd0) && (mag_y >= {2'b00, db_eff});

  // positive offset moves the angle down
  always_comb begin
    np = $signed({2'b00, pan_pos_r});
    nt = $signed({2'b00, tilt_pos_r});
    if (step_x) begin
      np = off_x[11] ? np + 10'sd1 : np - 10'sd1;
    end
    if (step_y) begin
      nt = off_y[11] ? nt + 10'sd1 : nt - 10'sd1;
    end
  end

  assign in_lim = (np >= $signed({2'b00, pan_min_r}))  && (np <= $signed({2'b00, pan_max_r})) &&
                  (nt >= $signed({2'b00, tilt_min_r})) && (nt <= $signed({2'b00, tilt_max_r}));

  assign miss_dec = miss_r[6] ? miss_r : miss_r - 7'sd1;

  always_comb begin
    status       = ptf_pkg::ST_NONE;
    show_in      = 1'b0;
    cx_o         = '0;
    cy_o         = '0;
    servo        = 1'b0;
    pan_pos_nxt  = pan_pos_r;
    tilt_pos_nxt = tilt_pos_r;
    miss_nxt     = miss_r;
    armed_nxt    = armed_r;
    flag_nxt     = flag_r;
    seed_ok_nxt  = seed_ok_r;
    unique case (in_tuser)
      ptf_pkg::CMD_SEED: begin
        show_in     = 1'b1;
        seed_ok_nxt = box_ok;
        armed_nxt   = 1'b0;
      end
      ptf_pkg::CMD_REPORT: begin
        tilt_pos_nxt = rep_tilt;
        pan_pos_nxt  = rep_pan;
      end
      ptf_pkg::CMD_TRACK: begin
        if (track_en_r) begin
          if (!seed_ok_r) begin
            flag_nxt  = 1'b0;
            armed_nxt = 1'b0;
            status    = ptf_pkg::ST_SEED_LOST;
          end else if (!armed_r) begin
            armed_nxt = 1'b1;
            status    = ptf_pkg::ST_START;
          end else begin
            show_in = 1'b1;
            if (!(box_ok && area_ok)) begin
              miss_nxt = miss_dec;
              if (miss_dec[6]) begin
                flag_nxt  = 1'b0;
                armed_nxt = 1'b0;
                status    = ptf_pkg::ST_MISS_LOST;
              end else begin
                status = ptf_pkg::ST_MISS_WAIT;
              end
            end else begin
              cx_o     = cx;
              cy_o     = cy;
              flag_nxt = 1'b1;
              miss_nxt = MISS_RST;
              if (!step_x && !step_y) begin
                status = ptf_pkg::ST_ON_TARGET;
              end else if (in_lim) begin
                pan_pos_nxt  = np[7:0];
                tilt_pos_nxt = nt[7:0];
                servo        = 1'b1;
                status       = ptf_pkg::ST_STEP;
              end else begin
                status = ptf_pkg::ST_AT_LIMIT;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign sb_l = show_in ? b_l : seed_r[0];
  assign sb_t = show_in ? b_t : seed_r[1];
  assign sb_r = show_in ? b_r : seed_r[2];
  assign sb_b = show_in ? b_b : seed_r[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_en_r   <= 1'b0;
      min_area_r   <= ptf_pkg::MIN_AREA_RST;
      max_area_r   <= ptf_pkg::MAX_AREA_RST;
      deadband_r   <= ptf_pkg::DEADBAND_RST;
      pan_min_r    <= ptf_pkg::PAN_MIN_RST;
      pan_max_r    <= ptf_pkg::PAN_MAX_RST;
      tilt_min_r   <= ptf_pkg::TILT_MIN_RST;
      tilt_max_r   <= ptf_pkg::TILT_MAX_RST;
      pan_pos_r    <= ptf_pkg::PAN_POS_RST;
      tilt_pos_r   <= ptf_pkg::TILT_POS_RST;
      miss_r       <= MISS_RST;
      armed_r      <= 1'b0;
      flag_r       <= 1'b1;
      seed_ok_r    <= 1'b0;
      seed_r[0]    <= '0;
      seed_r[1]    <= '0;
      seed_r[2]    <= '0;
      seed_r[3]    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        pan_pos_r   <= pan_pos_nxt;
        tilt_pos_r  <= tilt_pos_nxt;
        miss_r      <= miss_nxt;
        armed_r     <= armed_nxt;
        flag_r      <= flag_nxt;
        seed_ok_r   <= seed_ok_nxt;
        if (in_tuser == ptf_pkg::CMD_SEED) begin
          seed_r[0] <= b_l;
          seed_r[1] <= b_t;
          seed_r[2] <= b_r;
          seed_r[3] <= b_b;
        end
        out_tuser_r <= status;
        out_tdata_r <= {2'b00, flag_nxt, pan_pos_nxt, tilt_pos_nxt, servo,
                        cy_o, cx_o, sb_b, sb_r, sb_t, sb_l};
      end
      if (in_acc) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (cfg_wr) begin
        unique case (cfg_paddr[4:2])
          ptf_pkg::REG_TRACK_EN: begin
            track_en_r <= cfg_pwdata[0];
            if (!cfg_pwdata[0]) begin
              armed_r <= 1'b0;
            end
          end
          ptf_pkg::REG_MIN_AREA: min_area_r <= cfg_pwdata[18:0];
          ptf_pkg::REG_MAX_AREA: max_area_r <= cfg_pwdata[18:0];
          ptf_pkg::REG_DEADBAND: deadband_r <= cfg_pwdata[8:0];
          ptf_pkg::REG_PAN_MIN:  pan_min_r  <= cfg_pwdata[7:0];
          ptf_pkg::REG_PAN_MAX:  pan_max_r  <= cfg_pwdata[7:0];
          ptf_pkg::REG_TILT_MIN: tilt_min_r <= cfg_pwdata[7:0];
          ptf_pkg::REG_TILT_MAX: tilt_max_r <= cfg_pwdata[7:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    unique case (cfg_paddr[4:2])
      ptf_pkg::REG_TRACK_EN: cfg_prdata = {31'd0, track_en_r};
      ptf_pkg::REG_MIN_AREA: cfg_prdata = {13'd0, min_area_r};
      ptf_pkg::REG_MAX_AREA: cfg_prdata = {13'd0, max_area_r};
      ptf_pkg::REG_DEADBAND: cfg_prdata = {23'd0, deadband_r};
      ptf_pkg::REG_PAN_MIN:  cfg_prdata = {24'd0, pan_min_r};
      ptf_pkg::REG_PAN_MAX:  cfg_prdata = {24'd0, pan_max_r};
      ptf_pkg::REG_TILT_MIN: cfg_prdata = {24'd0, tilt_min_r};
      ptf_pkg::REG_TILT_MAX: cfg_prdata = {24'd0, tilt_max_r};
      default:               cfg_prdata = '0;
    endcase
  end

  a_servo_only_on_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> (out_tdata_r[68] == (out_tuser_r == ptf_pkg::ST_STEP)))
    else $error("servo_valid disagrees with step status");

  a_centre_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && (out_tuser_r != ptf_pkg::ST_ON_TARGET) &&
     (out_tuser_r != ptf_pkg::ST_STEP) && (out_tuser_r != ptf_pkg::ST_AT_LIMIT))
    |-> (out_tdata_r[67:48] == 20'd0))
    else $error("centre reported without a good box");

  a_miss_range: assert property (@(posedge clk) disable iff (!rst_n)
    (miss_r >= -7'sd1) && (miss_r <= MISS_RST))
    else $error("miss budget out of range");

  a_step_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (status == ptf_pkg::ST_STEP)) |=>
    ((pan_pos_r >= pan_min_r) && (pan_pos_r <= pan_max_r) &&
     (tilt_pos_r >= tilt_min_r) && (tilt_pos_r <= tilt_max_r)))
    else $error("servo step left its limits");

endmodule
